>>> rtl/core/fct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fct_pkg
// shared constants, codes and types of the frustum cull tester
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int NUM_PLANES = 6;
  localparam int NUM_COEFS  = NUM_PLANES * 4;
  localparam int PLANE_W    = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int ADDR_W     = $clog2(NUM_COEFS);

  // multiplier operands, product and accumulator widths
  localparam int OP_W   = 33;
  localparam int PROD_W = 2 * OP_W;
  localparam int ACC_W  = PROD_W + 2;

  // request kinds
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_POINT  = 2'd1;
  localparam logic [1:0] REQ_SPHERE = 2'd2;
  localparam logic [1:0] REQ_BOX    = 2'd3;

  // coefficient slots within a plane
  localparam logic [1:0] COEF_A = 2'd0;
  localparam logic [1:0] COEF_B = 2'd1;
  localparam logic [1:0] COEF_C = 2'd2;
  localparam logic [1:0] COEF_D = 2'd3;

  // terms of one plane sum, in issue order
  localparam int TERM_W = 3;
  localparam logic [TERM_W-1:0] TERM_D     = 3'd0;  // d * 2^16
  localparam logic [TERM_W-1:0] TERM_AX    = 3'd1;  // a * x
  localparam logic [TERM_W-1:0] TERM_BY    = 3'd2;  // b * y
  localparam logic [TERM_W-1:0] TERM_CZ    = 3'd3;  // c * z
  localparam logic [TERM_W-1:0] TERM_EXTRA = 3'd4;  // radius * 2^16 or |a| * hx
  localparam logic [TERM_W-1:0] TERM_BHY   = 3'd5;  // |b| * hy
  localparam logic [TERM_W-1:0] TERM_CHZ   = 3'd6;  // |c| * hz

  localparam logic signed [OP_W-1:0] Q_ONE = 33'sd65536;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [31:0]        data;
  } coef_wr_t;

  typedef struct packed {
    logic issue;
    logic first;
    logic last;
    logic last_plane;
  } mac_ctl_t;

  typedef struct packed {
    logic fail;
    logic all_done;
  } mac_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/fct_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fct_req_if
// request channel of the frustum cull tester: writes and shape tests
// ----------------------------------------------------------------------------
interface fct_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  plane_index;
  logic [1:0]  coef_index;
  logic [31:0] coef_value;
  logic [31:0] center_x;
  logic [31:0] center_y;
  logic [31:0] center_z;
  logic [30:0] half_x;
  logic [30:0] half_y;
  logic [30:0] half_z;
  logic [30:0] radius;

  modport source (
    output valid, req_type, plane_index, coef_index, coef_value,
           center_x, center_y, center_z, half_x, half_y, half_z, radius,
    input  ready
  );
  modport sink (
    input  valid, req_type, plane_index, coef_index, coef_value,
           center_x, center_y, center_z, half_x, half_y, half_z, radius,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/core/fct_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fct_res_if
// result channel of the frustum cull tester: one inside flag per test
// ----------------------------------------------------------------------------
interface fct_res_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface
`default_nettype wire

>>> rtl/core/fct_coef_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fct_coef_store
// plane coefficient registers, one write and one read port, cleared on reset
// ----------------------------------------------------------------------------
module fct_coef_store (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire fct_pkg::coef_wr_t         wr,
  input  wire logic [fct_pkg::ADDR_W-1:0] rd_addr,
  output logic [31:0]                    rd_data
);
  import fct_pkg::*;

  logic [31:0] coefs [NUM_COEFS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coefs[i] <= '0;
      end
    end else if (wr.en) begin
      coefs[wr.addr] <= wr.data;
    end
  end

  assign rd_data = coefs[rd_addr];

endmodule
`default_nettype wire

>>> rtl/core/fct_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fct_mac
// shared multiply-accumulate unit: registered product, then exact accumulate
// ----------------------------------------------------------------------------
module fct_mac (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire fct_pkg::mac_ctl_t               ctl,
  input  wire logic signed [fct_pkg::OP_W-1:0] op_a,
  input  wire logic signed [fct_pkg::OP_W-1:0] op_b,
  output fct_pkg::mac_sts_t                    sts
);
  import fct_pkg::*;

  logic signed [PROD_W-1:0] prod;
  mac_ctl_t                 prod_ctl;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W-1:0]  prod_ext;

  // product stage
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (rst) begin
      prod_ctl <= '0;
    end else begin
      prod_ctl <= ctl;
    end
  end

  assign prod_ext = ACC_W'(prod);
  assign acc_next = prod_ctl.first ? prod_ext : acc + prod_ext;

  // accumulate stage
  always_ff @(posedge clk) begin
    if (prod_ctl.issue) begin
      acc <= acc_next;
    end
    if (rst) begin
      sts <= '0;
    end else begin
      sts.fail       <= prod_ctl.issue && prod_ctl.last && acc_next[ACC_W-1];
      sts.all_done   <= prod_ctl.issue && prod_ctl.last && prod_ctl.last_plane;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/frustum_cull_tester.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_cull_tester
// six-plane view frustum culling of points, spheres and boxes
// ----------------------------------------------------------------------------
// usage
//   req: requests of four kinds. a write request loads one plane coefficient
//   (plane_index, coef_index, coef_value) and gives no result; a write to a
//   plane beyond the last is dropped. point, sphere and box tests give one
//   inside_res flag each on res.
//   each plane sum is built exactly by one shared 33x33 multiplier feeding a
//   68-bit accumulator, one term per cycle: 4 terms per plane for a point or
//   sphere's d, a, b, c, plus one radius term for a sphere, plus three
//   half-extent terms for a box.
//   req.ready is high only while the block is idle; it falls for the whole of
//   a test and stays low while the result waits on res. it rises again in the
//   cycle after the result is taken.
//   reset clears all coefficients to zero, so every test then answers inside.
//   a receiver that stalls simply holds the result register; nothing is lost.
// ----------------------------------------------------------------------------
module frustum_cull_tester (
  input  wire logic clk,
  input  wire logic rst,
  fct_req_if.sink   req,
  fct_res_if.source res
);
  import fct_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t              state, state_next;
  logic [PLANE_W-1:0]  plane, plane_next;
  logic [TERM_W-1:0]   term, term_next;
  logic                culled, culled_next;
  logic                out_valid, out_valid_next;
  logic                in_view, in_view_next;

  // captured test request, payload only
  logic [1:0]  kind;
  logic [31:0] cx, cy, cz;
  logic [30:0] hx, hy, hz, rad;

  coef_wr_t             wr;
  logic [1:0]           coef_sel;
  logic [ADDR_W-1:0]    rd_addr;
  logic [31:0]          rd_data;
  logic signed [OP_W-1:0] coef_s, coef_abs, op_a, op_b;
  logic                 last_term;
  mac_ctl_t             ctl;
  mac_sts_t             sts;
  logic                 accept;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  // coefficient writes land straight in the store
  assign wr.en   = accept && (req.req_type == REQ_WRITE)
                   && (req.plane_index < 3'(NUM_PLANES));
  assign wr.addr = ADDR_W'({req.plane_index, req.coef_index});
  assign wr.data = req.coef_value;

  // which coefficient the current term reads
  always_comb begin
    case (term)
      TERM_D:             coef_sel = COEF_D;
      TERM_AX, TERM_EXTRA: coef_sel = COEF_A;
      TERM_BY, TERM_BHY:  coef_sel = COEF_B;
      default:            coef_sel = COEF_C;
    endcase
  end

  assign rd_addr = ADDR_W'({plane, coef_sel});

  fct_coef_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign coef_s   = OP_W'($signed(rd_data));
  assign coef_abs = coef_s[OP_W-1] ? -coef_s : coef_s;

  // operand selection for the shared multiplier
  always_comb begin
    case (term)
      TERM_D: begin
        op_a = coef_s;
        op_b = Q_ONE;
      end
      TERM_AX: begin
        op_a = coef_s;
        op_b = OP_W'($signed(cx));
      end
      TERM_BY: begin
        op_a = coef_s;
        op_b = OP_W'($signed(cy));
      end
      TERM_CZ: begin
        op_a = coef_s;
        op_b = OP_W'($signed(cz));
      end
      TERM_EXTRA: begin
        if (kind == REQ_SPHERE) begin
          // radius moves the threshold from zero to minus radius
          op_a = $signed({2'b00, rad});
          op_b = Q_ONE;
        end else begin
          op_a = coef_abs;
          op_b = $signed({2'b00, hx});
        end
      end
      TERM_BHY: begin
        op_a = coef_abs;
        op_b = $signed({2'b00, hy});
      end
      default: begin
        op_a = coef_abs;
        op_b = $signed({2'b00, hz});
      end
    endcase
  end

  // last term of a plane depends on the shape
  always_comb begin
    case (kind)
      REQ_SPHERE: last_term = (term == TERM_EXTRA);
      REQ_BOX:    last_term = (term == TERM_CHZ);
      default:    last_term = (term == TERM_CZ);
    endcase
  end

  assign ctl.issue      = (state == ST_ISSUE);
  assign ctl.first      = (term == TERM_D);
  assign ctl.last       = last_term;
  assign ctl.last_plane = (plane == PLANE_W'(NUM_PLANES - 1));

  fct_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .op_a (op_a),
    .op_b (op_b),
    .sts  (sts)
  );

  // sequencer
  always_comb begin
    state_next     = state;
    plane_next     = plane;
    term_next      = term;
    culled_next    = culled | sts.fail;
    out_valid_next = out_valid;
    in_view_next   = in_view;
    case (state)
      ST_IDLE: begin
        if (accept && (req.req_type != REQ_WRITE)) begin
          state_next  = ST_ISSUE;
          plane_next  = '0;
          term_next   = TERM_D;
          culled_next = 1'b0;
        end
      end
      ST_ISSUE: begin
        if (last_term) begin
          term_next  = TERM_D;
          plane_next = plane + 1'b1;
          if (ctl.last_plane) begin
            state_next = ST_WAIT;
          end
        end else begin
          term_next = term + 1'b1;
        end
      end
      ST_WAIT: begin
        // last plane result arrives once its last term has passed the product and status registers
        if (sts.all_done) begin
          in_view_next   = !(culled | sts.fail);
          out_valid_next = 1'b1;
          state_next     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res.ready) begin
          out_valid_next = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      plane     <= '0;
      term      <= TERM_D;
      culled    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      plane     <= plane_next;
      term      <= term_next;
      culled    <= culled_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_view <= in_view_next;
    if (accept) begin
      kind <= req.req_type;
      cx   <= req.center_x;
      cy   <= req.center_y;
      cz   <= req.center_z;
      hx   <= req.half_x;
      hy   <= req.half_y;
      hz   <= req.half_z;
      rad  <= req.radius;
    end
  end

  assign res.valid      = out_valid;
  assign res.inside_res = in_view;

endmodule
`default_nettype wire
